@@ design/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes, error codes and helper functions for the
// infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

	// Default operator stack depth
	localparam int STACK_DEPTH_DEF = 32;

	// Field widths
	localparam int CHAR_W = 8;
	localparam int ERR_W  = 2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

	// Converter control states
	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	// Stack action decided in the current cycle
	typedef struct packed {
		logic              emit;
		logic              pop;
		logic              push;
		logic              done;
		logic [CHAR_W-1:0] chr;
		logic              term;
		logic [ERR_W-1:0]  err;
	} action_t;

	// Precedence rank: 0 for unknown characters, then 1..3
	function automatic logic [1:0] prec_rank(input logic [CHAR_W-1:0] c);
		logic [1:0] r;
		case (c)
			CH_PLUS, CH_MINUS: r = 2'd1;
			CH_STAR, CH_SLASH: r = 2'd2;
			CH_CARET:          r = 2'd3;
			default:           r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
	endfunction

endpackage

@@ design/itp_in_if.sv @@
// ----------------------------------------------------------------------------
// itp_in_if
// Input channel: one infix character or an end-of-expression mark.
// ----------------------------------------------------------------------------
interface itp_in_if;
	import itp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;
	logic              end_of_expr;

	modport source (output valid, output char_in, output end_of_expr, input ready);
	modport sink (input valid, input char_in, input end_of_expr, output ready);

endinterface

@@ design/itp_out_if.sv @@
// ----------------------------------------------------------------------------
// itp_out_if
// Output channel: one postfix character, terminator or error result.
// ----------------------------------------------------------------------------
interface itp_out_if;
	import itp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              is_terminator;
	logic [ERR_W-1:0]  error_code;

	modport source (output valid, output char_out, output is_terminator, output error_code,
		input ready);
	modport sink (input valid, input char_out, input is_terminator, input error_code,
		output ready);

endinterface

@@ design/itp_ram.sv @@
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/infix_to_postfix_converter.sv @@
// Flow: an item is taken only in the idle state, so no new item is accepted until
//   the last one is done. Each work cycle that the output does not stall pops one
//   stack entry or closes the item with a push, an emit or the pop of a matching
//   open parenthesis; an end mark pops every entry, then emits the terminator.
// Reset: state, stack count and output valid clear; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: operator stack kept in a RAM with the top entry
// cached in a register and the entry below it prefetched every cycle.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	itp_in_if.sink   in_ch,
	itp_out_if.source out_ch
);
	import itp_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t            state_q, state_next;
	action_t           act;
	logic [CHAR_W-1:0] cur_char_q;
	logic              cur_end_q;
	logic [CW-1:0]     count_q, count_next;
	logic [CHAR_W-1:0] top_q;
	logic [CHAR_W-1:0] below_rdata;
	logic [AW-1:0]     rd_addr;
	logic [CW-1:0]     rd_diff;
	logic              adv;
	logic              has_entry;
	logic              full;
	logic              top_is_lparen;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_term_q;
	logic [ERR_W-1:0]  out_err_q;

	assign adv           = !out_valid_q || out_ch.ready;
	assign has_entry     = (count_q != '0);
	assign full          = (count_q >= CW'(STACK_DEPTH));
	assign top_is_lparen = (top_q == CH_LPAREN);
	assign in_ch.ready   = (state_q == ST_IDLE);

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_next = ST_WORK;
				end
			end
			ST_WORK: begin
				if (act.done) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Decide the stack action for this cycle
	always_comb begin
		act = '0;
		unique case (state_q)
			ST_IDLE: begin
				act = '0;
			end
			ST_WORK: begin
				if (adv) begin
					if (cur_end_q) begin
						if (has_entry) begin
							act.emit = 1'b1;
							act.pop  = 1'b1;
							act.chr  = top_q;
						end else begin
							act.emit = 1'b1;
							act.term = 1'b1;
							act.chr  = CH_NUL;
							act.done = 1'b1;
						end
					end else if (is_letter(cur_char_q)) begin
						act.emit = 1'b1;
						act.chr  = cur_char_q;
						act.done = 1'b1;
					end else if (cur_char_q == CH_RPAREN) begin
						if (has_entry && !top_is_lparen) begin
							act.emit = 1'b1;
							act.pop  = 1'b1;
							act.chr  = top_q;
						end else if (has_entry) begin
							act.pop  = 1'b1;
							act.done = 1'b1;
						end else begin
							act.emit = 1'b1;
							act.chr  = CH_NUL;
							act.err  = ERR_UNMATCHED;
							act.done = 1'b1;
						end
					end else if ((cur_char_q != CH_LPAREN) && has_entry && !top_is_lparen &&
						(prec_rank(cur_char_q) <= prec_rank(top_q))) begin
						act.emit = 1'b1;
						act.pop  = 1'b1;
						act.chr  = top_q;
					end else if (full) begin
						act.emit = 1'b1;
						act.chr  = CH_NUL;
						act.err  = ERR_OVERFLOW;
						act.done = 1'b1;
					end else begin
						act.push = 1'b1;
						act.done = 1'b1;
					end
				end
			end
			default: act = '0;
		endcase
	end

	// Next count and prefetch address of the entry below the new top
	always_comb begin
		count_next = count_q;
		if (act.push) begin
			count_next = count_q + CW'(1);
		end else if (act.pop) begin
			count_next = count_q - CW'(1);
		end
		rd_diff = count_next - CW'(2);
		rd_addr = (count_next >= CW'(2)) ? rd_diff[AW-1:0] : '0;
	end

	itp_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (act.push),
		.waddr (count_q[AW-1:0]),
		.wdata (cur_char_q),
		.raddr (rd_addr),
		.rdata (below_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			count_q <= count_next;
			if (act.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the current item, cached top and output payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cur_char_q <= in_ch.char_in;
			cur_end_q  <= in_ch.end_of_expr;
		end
		if (act.push) begin
			top_q <= cur_char_q;
		end else if (act.pop) begin
			top_q <= below_rdata;
		end
		if (act.emit) begin
			out_char_q <= act.chr;
			out_term_q <= act.term;
			out_err_q  <= act.err;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.char_out      = out_char_q;
	assign out_ch.is_terminator = out_term_q;
	assign out_ch.error_code    = out_err_q;

endmodule

@@ tb/sv/infix_to_postfix_converter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_checker
// Watches both channels of the converter. Every input transfer runs through a
// shunting-yard predictor that queues the postfix results it must release;
// every output transfer is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_checker import itp_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	itp_in_if    in_ch,
	itp_out_if   out_ch,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen,
	output int   unmatched_seen,
	output int   overflow_seen,
	output int   exprs_seen
);

	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic              term;
		logic [ERR_W-1:0]  err;
	} postfix_t;

	// Postfix results still owed by the block, oldest first
	postfix_t postfix_q[$];

	// Predicted operator stack
	logic [CHAR_W-1:0] op_stack [STACK_DEPTH];
	int                depth;

	function automatic int op_rank(input logic [CHAR_W-1:0] c);
		int r;
		case (c)
			CH_PLUS, CH_MINUS: r = 1;
			CH_STAR, CH_SLASH: r = 2;
			CH_CARET:          r = 3;
			default:           r = -1;
		endcase
		return r;
	endfunction

	function automatic logic alpha(input logic [CHAR_W-1:0] c);
		return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
	endfunction

	task automatic owe(input logic [CHAR_W-1:0] chr, input logic term,
		input logic [ERR_W-1:0] err);
		postfix_q.push_back('{chr, term, err});
		if (err == ERR_UNMATCHED)
			unmatched_seen++;
		if (err == ERR_OVERFLOW)
			overflow_seen++;
		if (term)
			exprs_seen++;
	endtask

	task automatic release_top();
		owe(op_stack[depth-1], 1'b0, ERR_NONE);
		depth--;
	endtask

	// Push, or flag overflow and drop the character
	task automatic stack_push(input logic [CHAR_W-1:0] c);
		if (depth >= STACK_DEPTH) begin
			owe(CH_NUL, 1'b0, ERR_OVERFLOW);
		end else begin
			op_stack[depth] = c;
			depth++;
		end
	endtask

	task automatic convert(input logic [CHAR_W-1:0] c, input logic eoe);
		int p;
		if (eoe) begin
			// flush everything, unmatched opening parentheses included
			while (depth > 0)
				release_top();
			owe(CH_NUL, 1'b1, ERR_NONE);
		end else if (alpha(c)) begin
			owe(c, 1'b0, ERR_NONE);
		end else if (c == CH_LPAREN) begin
			stack_push(c);
		end else if (c == CH_RPAREN) begin
			while (depth > 0 && op_stack[depth-1] != CH_LPAREN)
				release_top();
			if (depth > 0)
				depth--;
			else
				owe(CH_NUL, 1'b0, ERR_UNMATCHED);
		end else begin
			// any other byte is an operator; unknown ones rank below everything
			p = op_rank(c);
			while (depth > 0 && op_stack[depth-1] != CH_LPAREN &&
				p <= op_rank(op_stack[depth-1]))
				release_top();
			stack_push(c);
		end
	endtask

	task automatic note_mismatch(input postfix_t want, input postfix_t got, input logic orphan);
		if (mismatches < 10) begin
			if (orphan)
				$display("%0t: unexpected result chr=%02h term=%0b err=%0d",
					$realtime, got.chr, got.term, got.err);
			else
				$display("%0t: mismatch: expected chr=%02h term=%0b err=%0d, got chr=%02h term=%0b err=%0d",
					$realtime, want.chr, want.term, want.err, got.chr, got.term, got.err);
		end
		mismatches++;
	endtask

	// Predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		postfix_t got;
		postfix_t want;
		if (!arst_n) begin
			postfix_q.delete();
			depth          = 0;
			mismatches     = 0;
			results_seen   = 0;
			unmatched_seen = 0;
			overflow_seen  = 0;
			exprs_seen     = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				convert(in_ch.char_in, in_ch.end_of_expr);
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.char_out, out_ch.is_terminator, out_ch.error_code};
				results_seen++;
				if (postfix_q.size() == 0) begin
					note_mismatch(got, got, 1'b1);
				end else begin
					want = postfix_q.pop_front();
					if (want !== got)
						note_mismatch(want, got, 1'b0);
				end
			end
		end
		outstanding = postfix_q.size();
	end

endmodule

@@ tb/sv/infix_to_postfix_converter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Drives infix characters into the converter: a directed pass over letters,
// operators, parentheses and odd bytes, then random expressions, broken
// sequences, noise and deep nesting that overflows the stack. Both channels
// idle in random bursts; the checker beside the block predicts the results.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;
	import itp_pkg::*;

	localparam int RAND_ITEMS   = 90;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = STACK_DEPTH_DEF + 8;

	logic clk;
	logic arst_n;
	logic in_taken;
	bit   calm;
	int   items;
	int   stuck;

	int mismatches;
	int outstanding;
	int results_seen;
	int unmatched_seen;
	int overflow_seen;
	int exprs_seen;

	itp_in_if  in_ch();
	itp_out_if out_ch();

	infix_to_postfix_converter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	infix_to_postfix_converter_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.unmatched_seen (unmatched_seen),
		.overflow_seen  (overflow_seen),
		.exprs_seen     (exprs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Record input transfers for the driver to see at the falling edge
	always @(posedge clk)
		in_taken <= in_ch.valid && in_ch.ready;

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Output side: stall in random bursts until the quiet tail
	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0 && !calm && $urandom_range(0, 7) == 0)
				stall = $urandom_range(1, 18);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one item, with an optional idle burst first; return after its transfer
	task automatic send_item(input logic [CHAR_W-1:0] c, input logic eoe);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.char_in     <= c;
		in_ch.end_of_expr <= eoe;
		do @(negedge clk); while (!in_taken);
		items++;
	endtask

	function automatic logic [CHAR_W-1:0] pick_letter();
		if ($urandom_range(0, 1))
			return CH_LC_A + CHAR_W'($urandom_range(0, 25));
		return CH_UC_A + CHAR_W'($urandom_range(0, 25));
	endfunction

	function automatic logic [CHAR_W-1:0] pick_operator();
		logic [CHAR_W-1:0] c;
		case ($urandom_range(0, 4))
			0:       c = CH_PLUS;
			1:       c = CH_MINUS;
			2:       c = CH_STAR;
			3:       c = CH_SLASH;
			default: c = CH_CARET;
		endcase
		return c;
	endfunction

	// Well-formed expression with random letters, operators and nesting
	task automatic send_expression();
		int terms;
		int open_cnt;
		terms = $urandom_range(1, 7);
		open_cnt = 0;
		for (int k = 0; k < terms; k++) begin
			while (open_cnt < 4 && $urandom_range(0, 3) == 0) begin
				send_item(CH_LPAREN, 1'b0);
				open_cnt++;
			end
			send_item(pick_letter(), 1'b0);
			while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
				send_item(CH_RPAREN, 1'b0);
				open_cnt--;
			end
			if (k < terms - 1)
				send_item(pick_operator(), 1'b0);
		end
		while (open_cnt > 0) begin
			send_item(CH_RPAREN, 1'b0);
			open_cnt--;
		end
		send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	// Token soup: stray parentheses, operators in a row, odd bytes
	task automatic send_broken();
		int n;
		n = $urandom_range(2, 10);
		repeat (n) begin
			case ($urandom_range(0, 4))
				0:       send_item(pick_letter(), 1'b0);
				1:       send_item(pick_operator(), 1'b0);
				2:       send_item(CH_LPAREN, 1'b0);
				3:       send_item(CH_RPAREN, 1'b0);
				default: send_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
			endcase
		end
		send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n)
			send_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
		if ($urandom_range(0, 1))
			send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	// Deep nesting around the stack limit, then one closing token
	task automatic send_deep(input int lo, input int hi);
		int n;
		n = $urandom_range(lo, hi);
		repeat (n) begin
			send_item(CH_LPAREN, 1'b0);
			if ($urandom_range(0, 3) == 0)
				send_item(pick_letter(), 1'b0);
		end
		case ($urandom_range(0, 2))
			0:       send_item(pick_operator(), 1'b0);
			1:       send_item(CH_LPAREN, 1'b0);
			default: send_item(CH_RPAREN, 1'b0);
		endcase
		send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	// Stimulus and verdict
	initial begin
		int base;
		int pick;
		arst_n            = 1'b0;
		calm              = 1'b0;
		items             = 0;
		stuck             = 0;
		in_ch.valid       = 1'b0;
		in_ch.char_in     = CH_NUL;
		in_ch.end_of_expr = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// letters at both ends of both cases, every operator, chained power
		send_item(CH_LC_A, 1'b0);
		send_item(CH_PLUS, 1'b0);
		send_item(CH_UC_A, 1'b0);
		send_item(CH_STAR, 1'b0);
		send_item(CH_LC_Z, 1'b0);
		send_item(CH_CARET, 1'b0);
		send_item(CH_UC_Z, 1'b0);
		send_item(CH_CARET, 1'b0);
		send_item(CH_LC_A + 8'd1, 1'b0);
		send_item(CH_MINUS, 1'b0);
		send_item(CH_UC_Z - 8'd1, 1'b0);
		send_item(CH_SLASH, 1'b0);
		send_item(CH_LC_Z - 8'd1, 1'b0);
		send_item(8'hFF, 1'b1);

		// unknown bytes next to the letter ranges, then an unmatched close
		send_item(CH_LPAREN, 1'b0);
		send_item(CH_UC_A - 8'd1, 1'b0);
		send_item(CH_UC_Z + 8'd1, 1'b0);
		send_item(CH_RPAREN, 1'b0);
		send_item(CH_RPAREN, 1'b0);
		send_item(CH_NUL, 1'b1);

		// unknown bytes pop operators; close without open; open left for the flush
		send_item(CH_PLUS, 1'b0);
		send_item(CH_NUL, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_LC_A - 8'd1, 1'b0);
		send_item(CH_LC_Z + 8'd1, 1'b0);
		send_item(CH_RPAREN, 1'b0);
		send_item(CH_LPAREN, 1'b0);
		send_item(CH_NUL, 1'b1);

		// random part, opening with a nest deep enough to overflow
		base = items;
		send_deep(33, 36);
		while (items - base < RAND_ITEMS) begin
			calm = (items - base >= RAND_ITEMS - 25);
			pick = $urandom_range(0, 99);
			if (pick < 65)
				send_expression();
			else if (pick < 80)
				send_broken();
			else if (pick < 93)
				send_noise();
			else
				send_deep(30, 36);
		end
		send_item(CH_NUL, 1'b1);
		in_ch.valid <= 1'b0;

		// drain, then give the block time for anything unpredicted
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d input transfers and %0d postfix results over %0d expressions",
			items, results_seen, exprs_seen);
		$display("error cases hit: %0d unmatched closing parentheses, %0d stack overflows",
			unmatched_seen, overflow_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
design/itp_pkg.sv
design/itp_in_if.sv
design/itp_out_if.sv
design/itp_ram.sv
design/infix_to_postfix_converter.sv
tb/sv/infix_to_postfix_converter_checker.sv
tb/sv/infix_to_postfix_converter_tb.sv
